// ===== hw/rtl/b64_pkg.sv =====
// ============================================================================
// b64_pkg: shared types and constants for the Base64 encoder
// Holds the character table, the front state type and the request record
// passed from the front to the back.
// ============================================================================
package b64_pkg;

	// Pad character '='
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// Request queue depth between front and back
	localparam int QUEUE_DEPTH = 2;

	// Position of the next byte within its three-byte group
	typedef enum logic [1:0] {
		PH_0 = 2'd0,
		PH_1 = 2'd1,
		PH_2 = 2'd2
	} phase_t;

	// One request: up to four characters produced by one input byte
	typedef struct packed {
		logic [3:0][5:0] sym;       // six-bit alphabet indexes
		logic [3:0]      pad;       // emit '=' in place of the symbol
		logic [1:0]      last_idx;  // index of the final character in this request
		logic            fin;       // final character closes the message
	} job_t;

	// Map a six-bit value to its standard alphabet character
	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] w;
		logic [7:0] c;
		begin
			w = {2'b00, v};
			if (v < 6'd26) begin
				c = w + 8'd65;
			end else if (v < 6'd52) begin
				c = w + 8'd71;          // 'a' - 26
			end else if (v < 6'd62) begin
				c = w - 8'd4;           // '0' - 52
			end else if (v == 6'd62) begin
				c = 8'h2B;              // '+'
			end else begin
				c = 8'h2F;              // '/'
			end
			return c;
		end
	endfunction

endpackage

// ===== hw/rtl/base64_encoder_core.sv =====
// ============================================================================
// base64_encoder_core: streaming Base64 encoder, standard alphabet
// Bytes in, Base64 characters out, with '=' padding on a final partial group.
// ============================================================================
// The front builds requests combinationally. In the cycle a byte is accepted,
// the front turns it into a request of one to four characters, and that
// request is written into the queue at the accepting edge. The back then
// emits one character per cycle from the output register while the receiver
// keeps popping. A byte therefore yields one to four characters. A full
// three-byte group gives four characters, so a steady stream is limited by
// the one-character output register. When the output register is free, the
// first character of a byte moves from the queue head into the output
// register and is then valid on the output. A two-entry request queue sits
// between the front and the back, so push is taken while earlier characters
// still wait to be popped. last_char marks the final character of a message.
module base64_encoder_core import b64_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] out_char,
	output logic       last_char
);

	job_t   front_job;
	job_t   head_job;
	phase_t front_phase;
	logic   take;
	logic   q_rd;
	logic   q_empty;

	assign take = push && !full;

	// Byte intake
	b64_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.job        (front_job),
		.phase      (front_phase)
	);

	// Request queue
	b64_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (take),
		.wr_job (front_job),
		.rd     (q_rd),
		.rd_job (head_job),
		.full   (full),
		.empty  (q_empty)
	);

	// Character emitter
	b64_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.head      (head_job),
		.q_rd      (q_rd),
		.pop       (pop),
		.empty     (empty),
		.out_char  (out_char),
		.last_char (last_char)
	);

	// A final byte returns the front to the start of a group
	a_final_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(take && final_byte) |=> (front_phase == PH_0))
		else $error("group position not cleared after final byte");

	// A non-final byte at the start of a group moves to the second position
	a_phase_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !final_byte && front_phase == PH_0) |=> (front_phase == PH_1))
		else $error("group position did not advance");

	// A pad that is not the last character is followed by a second pad
	a_double_pad: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && out_char == PAD_CHAR && !last_char)
		|=> (!empty && out_char == PAD_CHAR && last_char))
		else $error("first pad not followed by closing pad");

endmodule

// ===== hw/rtl/b64_front.sv =====
// ============================================================================
// b64_front: byte intake and group tracking
// Tracks the position in the three-byte group and the leftover low bits,
// and turns each accepted byte into one request of one to four characters.
// ============================================================================
module b64_front import b64_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output job_t       job,
	output phase_t     phase
);

	phase_t     phase_q;
	phase_t     phase_d;
	logic [3:0] carry_q;
	logic [3:0] carry_d;

	// Hold group position and leftover bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_0;
			carry_q <= 4'd0;
		end else if (take) begin
			phase_q <= phase_d;
			carry_q <= carry_d;
		end
	end

	// Build the request and the next group position
	always_comb begin
		job          = '0;
		job.fin      = final_byte;
		phase_d      = PH_0;
		carry_d      = 4'd0;
		case (phase_q)
			PH_1: begin
				job.sym[0] = {carry_q[1:0], data_byte[7:4]};
				if (final_byte) begin
					job.sym[1]   = {data_byte[3:0], 2'b00};
					job.pad[2]   = 1'b1;
					job.last_idx = 2'd2;
				end else begin
					job.last_idx = 2'd0;
					carry_d      = data_byte[3:0];
					phase_d      = PH_2;
				end
			end
			PH_2: begin
				job.sym[0]   = {carry_q, data_byte[7:6]};
				job.sym[1]   = data_byte[5:0];
				job.last_idx = 2'd1;
			end
			default: begin
				job.sym[0] = data_byte[7:2];
				if (final_byte) begin
					job.sym[1]   = {data_byte[1:0], 4'b0000};
					job.pad[2]   = 1'b1;
					job.pad[3]   = 1'b1;
					job.last_idx = 2'd3;
				end else begin
					job.last_idx = 2'd0;
					carry_d      = {2'b00, data_byte[1:0]};
					phase_d      = PH_1;
				end
			end
		endcase
	end

	assign phase = phase_q;

endmodule

// ===== hw/rtl/b64_queue.sv =====
// ============================================================================
// b64_queue: request queue between front and back
// Small register queue that lets the front and the back stall independently.
// ============================================================================
module b64_queue import b64_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  job_t wr_job,
	input  logic rd,
	output job_t rd_job,
	output logic full,
	output logic empty
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	job_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign full   = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign empty  = (count_q == '0);
	assign rd_job = mem_q[rd_ptr_q];

	// Store incoming requests
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/b64_back.sv =====
// ============================================================================
// b64_back: character emitter
// Walks the head request one character per cycle unless the receiver stalls,
// maps it through the alphabet, holds it in the output register until taken.
// ============================================================================
module b64_back import b64_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  job_t       head,
	output logic       q_rd,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] out_char,
	output logic       last_char
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] char_q;
	logic       last_q;
	logic       taken;
	logic       emit;
	logic       at_end;

	assign taken  = pop && valid_q;
	assign emit   = !q_empty && (!valid_q || taken);
	assign at_end = (idx_q == head.last_idx);
	assign q_rd   = emit && at_end;

	// Advance the character index within the head request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (emit) begin
				idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
			end
			if (emit) begin
				valid_q <= 1'b1;
			end else if (taken) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= head.pad[idx_q] ? PAD_CHAR : b64_char(head.sym[idx_q]);
			last_q <= head.fin && at_end;
		end
	end

	assign empty     = !valid_q;
	assign out_char  = char_q;
	assign last_char = last_q;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top: self-checking bench for base64_encoder_core
// Streams byte messages into the encoder and checks every character that
// comes out against a bit-accurate encoder model or typed text. The bench
// starts with a table of directed bytes, then runs random messages. Both
// sides of the queue interface idle and stall at random, with one long
// receiver stall and one full drain.
// ============================================================================
module tb_top;
	import b64_pkg::*;

	localparam int ITEMS          = 420;
	localparam int GAP_MAX        = 17;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES    = 16;
	localparam int CYCLE_LIMIT    = 200000;

	// Standard alphabet, index 0 in the leftmost byte
	localparam logic [8*64-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	// One expected output character
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} exp_char_t;

	// One directed row; n_typed == 0 means the encoder model supplies the output
	typedef struct packed {
		logic [7:0]  data;
		logic        fin;
		logic [2:0]  n_typed;
		logic [31:0] typed;     // characters left-justified
	} dir_row_t;

	localparam int NDIR = 20;
	localparam dir_row_t DIR_TAB [NDIR] = '{
		'{8'h00, 1'b1, 3'd4, "AA=="},   // lone zero byte after reset
		'{8'hFF, 1'b1, 3'd4, "/w=="},   // lone all-ones byte
		'{8'h00, 1'b0, 3'd1, "A   "},
		'{8'h00, 1'b1, 3'd3, "AA= "},   // two-byte message, one pad
		'{8'hFF, 1'b0, 3'd1, "/   "},
		'{8'hFF, 1'b0, 3'd1, "/   "},
		'{8'hFF, 1'b1, 3'd2, "//  "},   // full group closes the message
		'{8'hFF, 1'b0, 3'd1, "/   "},
		'{8'hFF, 1'b1, 3'd3, "/8= "},
		'{8'h4D, 1'b0, 3'd0, "    "},   // "Man", message left open
		'{8'h61, 1'b0, 3'd0, "    "},
		'{8'h6E, 1'b0, 3'd0, "    "},
		'{8'h80, 1'b0, 3'd0, "    "},
		'{8'h01, 1'b0, 3'd0, "    "},
		'{8'h3E, 1'b1, 3'd0, "    "},
		'{8'hFC, 1'b0, 3'd0, "    "},
		'{8'h03, 1'b1, 3'd0, "    "},
		'{8'h10, 1'b1, 3'd0, "    "},
		'{8'h55, 1'b0, 3'd0, "    "},
		'{8'hAA, 1'b1, 3'd0, "    "}
	};

	logic       clk;
	logic       arst_n     = 1'b0;
	logic       push       = 1'b0;
	logic       full;
	logic [7:0] data_byte  = 8'h00;
	logic       final_byte = 1'b0;
	logic       pop        = 1'b0;
	logic       empty;
	logic [7:0] out_char;
	logic       last_char;

	// Encoder model state
	phase_t     enc_phase = PH_0;
	logic [3:0] enc_carry = 4'h0;

	exp_char_t  pending_chars[$];
	int         mismatches   = 0;
	int         bytes_sent   = 0;
	bit         tx_burst     = 1'b0;
	bit         rx_burst     = 1'b0;
	bit         rx_hold_req  = 1'b0;

	base64_encoder_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.pop        (pop),
		.empty      (empty),
		.out_char   (out_char),
		.last_char  (last_char)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Map a six-bit index to its character
	function automatic logic [7:0] sym_char(input logic [5:0] v);
		return ALPHABET[8*(63 - int'(v)) +: 8];
	endfunction

	// Encode one byte: advance the group state and return the characters it yields
	function automatic int encode_byte(input logic [7:0] b, input logic fin,
			output exp_char_t res[4]);
		int n;
		n = 0;
		for (int k = 0; k < 4; k++) begin
			res[k] = '0;
		end
		case (enc_phase)
			PH_1: begin
				res[0] = '{sym_char({enc_carry[1:0], b[7:4]}), 1'b0};
				if (fin) begin
					res[1] = '{sym_char({b[3:0], 2'b00}), 1'b0};
					res[2] = '{PAD_CHAR, 1'b1};
					enc_phase = PH_0;
					enc_carry = 4'h0;
					n = 3;
				end else begin
					enc_carry = b[3:0];
					enc_phase = PH_2;
					n = 1;
				end
			end
			PH_2: begin
				res[0] = '{sym_char({enc_carry, b[7:6]}), 1'b0};
				res[1] = '{sym_char(b[5:0]), fin};
				enc_phase = PH_0;
				enc_carry = 4'h0;
				n = 2;
			end
			default: begin
				// start of a group; an out-of-range phase lands here as well
				res[0] = '{sym_char(b[7:2]), 1'b0};
				if (fin) begin
					res[1] = '{sym_char({b[1:0], 4'h0}), 1'b0};
					res[2] = '{PAD_CHAR, 1'b0};
					res[3] = '{PAD_CHAR, 1'b1};
					enc_phase = PH_0;
					enc_carry = 4'h0;
					n = 4;
				end else begin
					enc_carry = {2'b00, b[1:0]};
					enc_phase = PH_1;
					n = 1;
				end
			end
		endcase
		return n;
	endfunction

	// Offer one byte request, wait for it to be taken, then queue its characters
	task automatic send_byte(input logic [7:0] b, input logic fin,
			input logic [2:0] n_typed, input logic [31:0] typed);
		exp_char_t pred[4];
		int        n;
		int        gap;
		gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push       <= 1'b1;
		data_byte  <= b;
		final_byte <= fin;
		do @(posedge clk); while (full);
		bytes_sent++;
		n = encode_byte(b, fin, pred);
		if (n_typed != 3'd0) begin
			for (int k = 0; k < int'(n_typed); k++) begin
				pending_chars.push_back('{typed[31 - 8*k -: 8],
					fin && (k == int'(n_typed) - 1)});
			end
		end else begin
			for (int k = 0; k < n; k++) begin
				pending_chars.push_back(pred[k]);
			end
		end
	endtask

	// Compare one popped character with the oldest expectation
	task automatic check_char();
		exp_char_t e;
		if (pending_chars.size() == 0) begin
			mismatches++;
			$display("%0t: unexpected char: expected none, actual %h last %b",
				$time, out_char, last_char);
		end else begin
			e = pending_chars.pop_front();
			if (out_char !== e.ch) begin
				mismatches++;
				$display("%0t: out_char mismatch: expected %h, actual %h",
					$time, e.ch, out_char);
			end
			if (last_char !== e.last) begin
				mismatches++;
				$display("%0t: last_char mismatch: expected %b, actual %b",
					$time, e.last, last_char);
			end
		end
	endtask

	// Receiver: random pop gaps, bursts, and one long stall on demand
	initial begin
		int gap;
		int popped;
		popped = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				pop <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
			end else begin
				gap = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
				if (gap > 0) begin
					pop <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			check_char();
			popped++;
			if (popped % 32 == 0) begin
				rx_burst = ($urandom_range(0, 2) == 0);
			end
		end
	end

	// Watchdog
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	// Stimulus and end of run
	initial begin
		int         len;
		int         msg;
		logic [7:0] b;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < NDIR; i++) begin
			send_byte(DIR_TAB[i].data, DIR_TAB[i].fin, DIR_TAB[i].n_typed,
				DIR_TAB[i].typed);
		end

		// random messages
		msg = 0;
		while (bytes_sent < ITEMS) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24)
				: $urandom_range(1, 6);
			tx_burst = ($urandom_range(0, 3) == 0);
			if (msg == 8) begin
				// stall the receiver while requests keep coming
				tx_burst = 1'b1;
				rx_hold_req = 1'b1;
			end
			if (msg == 45) begin
				// pause until every character has been popped
				push <= 1'b0;
				do @(posedge clk); while (pending_chars.size() != 0);
			end
			for (int k = 0; k < len; k++) begin
				case ($urandom_range(0, 9))
					0:       b = 8'h00;
					1:       b = 8'hFF;
					default: b = 8'($urandom_range(0, 255));
				endcase
				send_byte(b, k == len - 1, 3'd0, 32'h0);
			end
			msg++;
		end
		push <= 1'b0;

		// drain, then watch for stray output
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
